[design/height_to_normal_pixel_macros.svh]
// ----------------------------------------------------------------------------
// Height to normal pixel: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_PIXEL_MACROS_SVH
`define HEIGHT_TO_NORMAL_PIXEL_MACROS_SVH

// same-cycle implication
`define HNP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HNP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/hnp_pkg.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel: package
// Widths, pipeline geometry, register indexes and the odd-square table.
// ----------------------------------------------------------------------------
package hnp_pkg;

   // pipeline geometry: 3 front stages, 16 search stages, 1 output stage
   localparam int FRONT_STAGES = 3;
   localparam int LANE_STAGES  = 16;
   localparam int NUM_STAGES   = FRONT_STAGES + LANE_STAGES + 1;

   // datapath widths
   localparam int A_W    = 24;  // (right-left)*force, signed
   localparam int DZ_W   = 25;  // 2*d*65280
   localparam int ASQ_W  = 46;
   localparam int DZSQ_W = 50;
   localparam int Q_W    = 51;  // sum of squares
   localparam int RHS_W  = 66;  // 65025 * x^2
   localparam int PROD_W = 67;  // m^2 * q

   localparam int DZ_SCALE    = 130560;  // 2 * 255 * 256
   localparam int COMP_SCALE  = 65025;   // 255^2

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FORCE = 1'b0;
   localparam logic CSR_IDX_DIST  = 1'b1;
   localparam logic [15:0] FORCE_RESET = 16'd256;
   localparam logic [7:0]  DIST_RESET  = 8'd1;

   // (2c-255)^2 for every candidate level c
   typedef logic [15:0] sq_tab_type [256];

   function automatic sq_tab_type build_sq_tab();
      sq_tab_type t;
      int m;
      for (int c = 0; c < 256; c++) begin
         m    = 2 * c - 255;
         t[c] = 16'(m * m);
      end
      return t;
   endfunction

   localparam sq_tab_type SQ_TAB = build_sq_tab();

endpackage

[design/hnp_req_if.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel: channel interfaces
// Request channel (neighbor heights) and response channel (normal RGB).
// ----------------------------------------------------------------------------
interface hnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_height;
   logic [7:0] right_height;
   logic [7:0] up_height;
   logic [7:0] down_height;

   modport source (output valid, left_height, right_height, up_height, down_height,
                   input ready);
   modport sink (input valid, left_height, right_height, up_height, down_height,
                 output ready);
endinterface

interface hnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] normal_red;
   logic [7:0] normal_green;
   logic [7:0] normal_blue;

   modport source (output valid, normal_red, normal_green, normal_blue, input ready);
   modport sink (input valid, normal_red, normal_green, normal_blue, output ready);
endinterface

[design/hnp_search_lane.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel: search lane
// Finds the largest level k with (2k-255)*sqrt(q) <= 255*x, one bit per two
// stages: a product stage (m^2 * q) and a compare stage.
// ----------------------------------------------------------------------------
module hnp_search_lane (
   input  logic                             clock,
   input  logic [hnp_pkg::LANE_STAGES-1:0]  stage_en,
   input  logic [hnp_pkg::Q_W-1:0]          q_val,
   input  logic [hnp_pkg::RHS_W-1:0]        rhs_val,
   input  logic                             x_neg,
   output logic [7:0]                       level
);
   import hnp_pkg::*;

   // product stage registers
   logic [7:0]        cand_ff [8];
   logic [PROD_W-1:0] lhs_ff  [8];
   logic [RHS_W-1:0]  ra_ff   [8];
   logic              xa_ff   [8];
   logic [Q_W-1:0]    qa_ff   [8];

   // compare stage registers
   logic [7:0]        kb_ff [8];
   logic [Q_W-1:0]    qb_ff [7];
   logic [RHS_W-1:0]  rb_ff [7];
   logic              xb_ff [7];

   for (genvar j = 0; j < 8; j++) begin : g_step
      localparam logic [7:0] STEP_BIT = 8'h80 >> j;
      logic [7:0]       k_prev;
      logic [Q_W-1:0]   q_prev;
      logic [RHS_W-1:0] r_prev;
      logic             x_prev;
      logic [7:0]       cand_in;
      logic             hold_ok;

      if (j == 0) begin : g_first
         assign k_prev = 8'd0;
         assign q_prev = q_val;
         assign r_prev = rhs_val;
         assign x_prev = x_neg;
      end else begin : g_next
         assign k_prev = kb_ff[j-1];
         assign q_prev = qb_ff[j-1];
         assign r_prev = rb_ff[j-1];
         assign x_prev = xb_ff[j-1];
      end

      // try the next bit set
      assign cand_in = k_prev | STEP_BIT;

      always_ff @(posedge clock) begin
         if (stage_en[2*j]) begin
            cand_ff[j] <= cand_in;
            lhs_ff[j]  <= PROD_W'(SQ_TAB[cand_in]) * PROD_W'(q_prev);
            ra_ff[j]   <= r_prev;
            xa_ff[j]   <= x_prev;
            qa_ff[j]   <= q_prev;
         end
      end

      // m > 0 needs x >= 0 and m^2 q <= 255^2 x^2; m < 0 with x < 0 the reverse
      always_comb begin
         if (cand_ff[j][7]) begin
            hold_ok = !xa_ff[j] && (lhs_ff[j] <= PROD_W'(ra_ff[j]));
         end else if (xa_ff[j]) begin
            hold_ok = PROD_W'(ra_ff[j]) <= lhs_ff[j];
         end else begin
            hold_ok = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[2*j+1]) begin
            kb_ff[j] <= hold_ok ? cand_ff[j] : (cand_ff[j] & ~STEP_BIT);
         end
      end

      if (j < 7) begin : g_pass
         always_ff @(posedge clock) begin
            if (stage_en[2*j+1]) begin
               qb_ff[j] <= qa_ff[j];
               rb_ff[j] <= ra_ff[j];
               xb_ff[j] <= xa_ff[j];
            end
         end
      end
   end

   assign level = kb_ff[7];

endmodule

[design/height_to_normal_pixel.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel
// Central-difference normal of one pixel from four neighbor heights.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries the left, right, up and down heights of one pixel; rsp_ch
//   returns the normal as (red, green, blue) bytes, each floor((n+1)/2*255),
//   exact. Both channels use valid/ready; a request moves when both are high.
//   csr_* is an APB-style port: force_cfg (signed Q8.8) at 0x0 and
//   neighbor_distance at 0x4 (0 acts as 1). Write only while the block is idle.
// Timing:
//   One request per clock unless a stalled response fills the pipeline. Three
//   front stages (gradient, squares, sum), 16 search stages (two per output
//   bit: a 51x16 product of square and sum, then a wide compare), and the output stage.
// Stall:
//   Each stage holds while its successor is full and stalled; empty stages
//   keep filling, so requests are taken until the pipeline is full.
// Reset:
//   Synchronous; clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module height_to_normal_pixel (
   input  logic                            clock,
   input  logic                            reset,
   hnp_req_if.sink                         req_ch,
   hnp_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hnp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import hnp_pkg::*;

   localparam int OUT_STAGE = NUM_STAGES - 1;

   // configuration registers
   logic [15:0] force_cfg_ff;
   logic [7:0]  dist_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_cfg_ff <= FORCE_RESET;
         dist_ff      <= DIST_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_FORCE) begin
            force_cfg_ff <= csr_pwdata[15:0];
         end else begin
            dist_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DIST) ? {24'd0, dist_ff}
                                                      : {16'd0, force_cfg_ff};

   // stage valids and per-stage load enables
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   stage_en;

   assign stage_en[NUM_STAGES] = rsp_ch.ready;
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
      assign stage_en[i] = !valid_ff[i] || stage_en[i+1];
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign req_ch.ready = stage_en[0];

   // stage 0: gradients times force, flat component
   logic signed [8:0]      dx;
   logic signed [8:0]      dy;
   logic signed [A_W:0]    ax_full;
   logic signed [A_W:0]    by_full;
   logic [7:0]             dist_eff;
   logic signed [A_W-1:0]  a0_ff;
   logic signed [A_W-1:0]  b0_ff;
   logic [DZ_W-1:0]        dz0_ff;

   assign dx       = $signed({1'b0, req_ch.right_height}) - $signed({1'b0, req_ch.left_height});
   assign dy       = $signed({1'b0, req_ch.down_height}) - $signed({1'b0, req_ch.up_height});
   assign ax_full  = dx * $signed(force_cfg_ff);
   assign by_full  = dy * $signed(force_cfg_ff);
   assign dist_eff = (dist_ff == 8'd0) ? 8'd1 : dist_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a0_ff  <= ax_full[A_W-1:0];
         b0_ff  <= by_full[A_W-1:0];
         dz0_ff <= DZ_W'(dist_eff) * DZ_W'(DZ_SCALE);
      end
   end

   // stage 1: squares; red/green take x = -a, negative when a > 0
   logic signed [2*A_W-1:0] a_sq_full;
   logic signed [2*A_W-1:0] b_sq_full;
   logic [ASQ_W-1:0]        a1_sq_ff;
   logic [ASQ_W-1:0]        b1_sq_ff;
   logic [DZSQ_W-1:0]       dz1_sq_ff;
   logic                    a1_neg_ff;
   logic                    b1_neg_ff;

   assign a_sq_full = a0_ff * a0_ff;
   assign b_sq_full = b0_ff * b0_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         a1_sq_ff  <= a_sq_full[ASQ_W-1:0];
         b1_sq_ff  <= b_sq_full[ASQ_W-1:0];
         dz1_sq_ff <= DZSQ_W'(dz0_ff) * DZSQ_W'(dz0_ff);
         a1_neg_ff <= !a0_ff[A_W-1] && (a0_ff != '0);
         b1_neg_ff <= !b0_ff[A_W-1] && (b0_ff != '0);
      end
   end

   // stage 2: sum of squares and 255^2 * x^2 per component
   logic [Q_W-1:0]   q2_ff;
   logic [RHS_W-1:0] red_rhs_ff;
   logic [RHS_W-1:0] green_rhs_ff;
   logic [RHS_W-1:0] blue_rhs_ff;
   logic             red_neg_ff;
   logic             green_neg_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         q2_ff        <= Q_W'(a1_sq_ff) + Q_W'(b1_sq_ff) + Q_W'(dz1_sq_ff);
         red_rhs_ff   <= RHS_W'(a1_sq_ff) * RHS_W'(COMP_SCALE);
         green_rhs_ff <= RHS_W'(b1_sq_ff) * RHS_W'(COMP_SCALE);
         blue_rhs_ff  <= RHS_W'(dz1_sq_ff) * RHS_W'(COMP_SCALE);
         red_neg_ff   <= a1_neg_ff;
         green_neg_ff <= b1_neg_ff;
      end
   end

   // stages 3..18: bitwise level search per component
   logic [LANE_STAGES-1:0] lane_en;
   logic [7:0]             red_level;
   logic [7:0]             green_level;
   logic [7:0]             blue_level;

   assign lane_en = stage_en[FRONT_STAGES +: LANE_STAGES];

   hnp_search_lane u_red (
      .clock    (clock),
      .stage_en (lane_en),
      .q_val    (q2_ff),
      .rhs_val  (red_rhs_ff),
      .x_neg    (red_neg_ff),
      .level    (red_level)
   );

   hnp_search_lane u_green (
      .clock    (clock),
      .stage_en (lane_en),
      .q_val    (q2_ff),
      .rhs_val  (green_rhs_ff),
      .x_neg    (green_neg_ff),
      .level    (green_level)
   );

   hnp_search_lane u_blue (
      .clock    (clock),
      .stage_en (lane_en),
      .q_val    (q2_ff),
      .rhs_val  (blue_rhs_ff),
      .x_neg    (1'b0),
      .level    (blue_level)
   );

   // output stage
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;

   always_ff @(posedge clock) begin
      if (stage_en[OUT_STAGE]) begin
         red_ff   <= red_level;
         green_ff <= green_level;
         blue_ff  <= blue_level;
      end
   end

   assign rsp_ch.valid        = valid_ff[OUT_STAGE];
   assign rsp_ch.normal_red   = red_ff;
   assign rsp_ch.normal_green = green_ff;
   assign rsp_ch.normal_blue  = blue_ff;

endmodule

[design/hnp_checker.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel: port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "height_to_normal_pixel_macros.svh"

module hnp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] normal_red,
   input logic [7:0] normal_green,
   input logic [7:0] normal_blue,
   input logic       csr_pready
);

   // stalled response holds
   `HNP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(normal_red) && $stable(normal_green) && $stable(normal_blue), "stalled response changed")

   // with no response waiting every stage can load, so requests are taken
   `HNP_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "request refused while output empty")

   // a free output side never blocks the input
   `HNP_ASSERT_NOW(a_ready_when_taken, clock, reset, rsp_ready, req_ready, "request refused while response taken")

   // register port never waits
   `HNP_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready, "csr pready low")

endmodule

bind height_to_normal_pixel hnp_checker u_hnp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .normal_red   (rsp_ch.normal_red),
   .normal_green (rsp_ch.normal_green),
   .normal_blue  (rsp_ch.normal_blue),
   .csr_pready   (csr_pready)
);

[test/height_to_normal_pixel_test.sv]
// ----------------------------------------------------------------------------
// Height to normal pixel: testbench
// Streams neighbor-height requests through the block under several gain and
// distance settings and random idling on both channels. Every normal that
// comes back is compared, component by component, with an exact integer
// prediction computed here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
} normal_rgb_type;

class normal_scoreboard;
   normal_rgb_type pending[$];
   logic signed [15:0] gain;
   logic [7:0] nb_dist;
   int errors;
   int checked;

   function new();
      gain = 16'sd256;
      nb_dist = 8'd1;
      errors = 0;
      checked = 0;
   endfunction

   // (2k-255)*sqrt(q) <= 255*x, decided on squares
   function automatic bit level_fits(int k, longint x, longint unsigned q);
      longint m;
      logic [127:0] lhs, rhs;
      logic [63:0] ax;
      m = 2 * k - 255;
      if (m <= 0 && x >= 0) return 1;
      if (m > 0 && x < 0) return 0;
      ax = (x < 0) ? -x : x;
      lhs = 128'(m * m) * 128'(q);
      rhs = 128'd65025 * 128'(ax) * 128'(ax);
      return (m > 0) ? (lhs <= rhs) : (rhs <= lhs);
   endfunction

   function automatic logic [7:0] component_level(longint x, longint unsigned q);
      int lo, hi, mid;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (level_fits(mid, x, q)) lo = mid;
         else hi = mid - 1;
      end
      return 8'(lo);
   endfunction

   function void note_request(logic [7:0] l, logic [7:0] r, logic [7:0] u,
                              logic [7:0] d);
      longint a, b, dz, f, dd;
      longint unsigned q;
      normal_rgb_type n;
      f = gain;
      dd = (nb_dist == 0) ? 1 : nb_dist;
      a = (longint'(r) - longint'(l)) * f;
      b = (longint'(d) - longint'(u)) * f;
      dz = 2 * dd * 65280;
      q = a * a + b * b + dz * dz;
      n.red = component_level(-a, q);
      n.green = component_level(-b, q);
      n.blue = component_level(dz, q);
      pending.push_back(n);
   endfunction

   function void check_normal(normal_rgb_type got);
      normal_rgb_type want;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected normal %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
         $error("normal_red expected %0d actual %0d", want.red, got.red);
         errors++;
      end
      if (got.green !== want.green) begin
         $error("normal_green expected %0d actual %0d", want.green, got.green);
         errors++;
      end
      if (got.blue !== want.blue) begin
         $error("normal_blue expected %0d actual %0d", want.blue, got.blue);
         errors++;
      end
   endfunction
endclass

module height_to_normal_pixel_test;
   import hnp_pkg::*;

   localparam int LATENCY = NUM_STAGES;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FORCE = 3'(4 * CSR_IDX_FORCE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_DIST  = 3'(4 * CSR_IDX_DIST);

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent = 0;

   hnp_req_if req_ch();
   hnp_rsp_if rsp_ch();
   normal_scoreboard board = new();

   height_to_normal_pixel u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.left_height = 0;
      req_ch.right_height = 0;
      req_ch.up_height = 0;
      req_ch.down_height = 0;
      rsp_ch.ready = 0;
   end

   // response side: random stall, check on handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_normal({rsp_ch.normal_red, rsp_ch.normal_green,
                                rsp_ch.normal_blue});
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == ADDR_FORCE) board.gain = data[15:0];
      else board.nb_dist = data[7:0];
   endtask

   // one request; valid stays high between back-to-back requests
   task automatic send_heights(logic [7:0] l, logic [7:0] r, logic [7:0] u,
                               logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.left_height <= l;
      req_ch.right_height <= r;
      req_ch.up_height <= u;
      req_ch.down_height <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(l, r, u, d);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_burst(int count);
      logic [7:0] l, r, u, d;
      for (int i = 0; i < count; i++) begin
         l = 8'($urandom);
         u = 8'($urandom);
         case ($urandom_range(3))
            0: begin r = 8'($urandom); d = 8'($urandom); end
            1: begin
               r = 8'(l + $urandom_range(8) - 4);
               d = 8'(u + $urandom_range(8) - 4);
            end
            2: begin r = l; d = u; end
            default: begin r = $urandom_range(1) ? 8'd255 : 8'd0; d = ~r; end
         endcase
         send_heights(l, r, u, d);
      end
   endtask

   initial begin
      logic [15:0] gains [6];
      logic [7:0] dists [6];
      gains = '{16'h0100, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0040};
      dists = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd128, 8'd1};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset defaults, extremes, flat and zero distance
      send_heights(0, 0, 0, 0);
      send_heights(255, 255, 255, 255);
      send_heights(0, 255, 0, 255);
      send_heights(255, 0, 255, 0);
      send_heights(0, 255, 255, 0);
      send_heights(128, 127, 1, 254);
      send_heights(8'hAA, 8'h55, 8'h55, 8'hAA);
      drain();
      for (int g = 0; g < 6; g++) begin
         csr_write(ADDR_FORCE, 32'(gains[g]));
         csr_write(ADDR_DIST, 32'(dists[g]));
         send_heights(0, 255, 255, 0);
         send_heights(255, 0, 0, 255);
         send_heights(17, 17, 200, 200);
         drain();
      end

      // random phases across idle patterns and register settings
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         csr_write(ADDR_FORCE, (p == 0) ? 32'h0100 : 32'($urandom_range(65535)));
         csr_write(ADDR_DIST, (p == 7) ? 32'd0 : 32'($urandom_range(255)));
         random_burst(70);
         // full hold-off until the pipeline is empty
         drain();
         random_burst(70);
         drain();
      end

      $display("covered %0d requests, %0d normals checked, 14 register settings",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[filelist.f]
+incdir+design
design/hnp_pkg.sv
design/hnp_req_if.sv
design/hnp_search_lane.sv
design/height_to_normal_pixel.sv
design/hnp_checker.sv
test/height_to_normal_pixel_test.sv
